### hw/rtl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       recolored;
  } res_t;

  localparam logic [1:0] REG_ALPHA_THR = 2'd0;
  localparam logic [1:0] REG_HUE_START = 2'd1;
  localparam logic [1:0] REG_HUE_END   = 2'd2;
  localparam logic [1:0] REG_HUE_SHIFT = 2'd3;

  localparam logic [7:0]  ALPHA_THR_RST = 8'd0;
  localparam logic [12:0] HUE_START_RST = 13'd0;
  localparam logic [12:0] HUE_END_RST   = 13'd5759;
  localparam logic [12:0] HUE_SHIFT_RST = 13'd0;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

`default_nettype wire

### hw/rtl/shs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module shs_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 8,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               out_valid_o,
  output logic [QW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned WW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_q  [QW];
  logic [WW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [WW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [WW-1:0] dsh;
    logic          take;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rem_in  = WW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh  = WW'(den_in) << (QW - 1 - k);
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? (rem_in - dsh) : rem_in;
      den_q[k]  <= den_in;
      quo_q[k]  <= take ? (quo_in | (QW'(1) << (QW - 1 - k))) : quo_in;
      side_q[k] <= side_in;
    end
  end

  assign out_valid_o = vld_q[QW-1];
  assign quo_o       = quo_q[QW-1];
  assign side_o      = side_q[QW-1];

endmodule

`default_nettype wire

### hw/rtl/selective_hue_shift.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// pixel     in         start high, busy low       pix_i   (red, green, blue, alpha)
// result    out        out_valid_o for one cycle  res_o   (channels, alpha, recolored)
// config    in         APB write, pready high     paddr, pwdata, prdata
//
// One word enters every clock cycle; the restoring hue divider sets the pipeline depth.
// busy stays low, since the pipeline never stalls and the receiver cannot stall.
// Reset clears the valid bits of every stage and loads the register reset values.
module selective_hue_shift
  import shs_pkg::*;
#(
  parameter int unsigned HUE_STEPS_PER_DEGREE = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire pix_t        pix_i,
  output logic             out_valid_o,
  output res_t             res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned P    = 60 * HUE_STEPS_PER_DEGREE;
  localparam int unsigned F    = 360 * HUE_STEPS_PER_DEGREE;
  localparam int unsigned HW   = $clog2(F);
  localparam int unsigned QW1  = $clog2(F + 1);
  localparam int unsigned N1W  = $clog2(2 * P * 1529 + 256);
  localparam int unsigned D1W  = 9;
  localparam int unsigned SRB  = $clog2(8191 / F + 1);
  localparam int unsigned CW   = (HW > 13) ? HW : 13;
  localparam int unsigned PW   = $clog2(P + 1);
  localparam int unsigned N2W  = $clog2(511 * P + 1);
  localparam int unsigned QW2  = 8;
  localparam int unsigned RSH  = N2W + $clog2(2 * P);
  localparam longint unsigned RMUL = ((64'd1 << RSH) + 64'(2 * P) - 64'd1) / 64'(2 * P);
  localparam int unsigned RMW  = $clog2(RMUL + 1);
  localparam int unsigned PRW  = N2W + RMW;
  localparam int unsigned LAT  = 8 + QW1;

  typedef struct packed {
    pix_t       pix;
    logic [7:0] mn;
    logic [7:0] chroma;
    logic       skip;
  } s1_t;

  typedef struct packed {
    pix_t       pix;
    logic [7:0] mn;
    logic [7:0] chroma;
    logic       recolor;
    logic [2:0] sector;
  } s2_t;

  // Configuration registers.
  logic [7:0]    alpha_thr_q;
  logic [12:0]   hue_start_q;
  logic [12:0]   hue_end_q;
  logic [12:0]   hue_shift_q;
  logic [HW-1:0] shift_red_q, shift_red_d;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_thr_q <= ALPHA_THR_RST;
      hue_start_q <= HUE_START_RST;
      hue_end_q   <= HUE_END_RST;
      hue_shift_q <= HUE_SHIFT_RST;
      shift_red_q <= '0;
    end else begin
      shift_red_q <= shift_red_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ALPHA_THR: alpha_thr_q <= pwdata[7:0];
          REG_HUE_START: hue_start_q <= pwdata[12:0];
          REG_HUE_END:   hue_end_q   <= pwdata[12:0];
          REG_HUE_SHIFT: hue_shift_q <= pwdata[12:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA_THR: prdata = {24'd0, alpha_thr_q};
      REG_HUE_START: prdata = {19'd0, hue_start_q};
      REG_HUE_END:   prdata = {19'd0, hue_end_q};
      REG_HUE_SHIFT: prdata = {19'd0, hue_shift_q};
      default:       prdata = '0;
    endcase
  end

  // The shift reduced below one full circle, ready long before any word needs it.
  always_comb begin
    logic [12:0] acc;
    acc = hue_shift_q;
    for (int b = int'(SRB) - 1; b >= 0; b--) begin
      if (acc >= (13'(F) << b)) begin
        acc = acc - (13'(F) << b);
      end
    end
    shift_red_d = HW'(acc);
  end

  // Stage 0: input register.
  logic vld0_q;
  pix_t pix0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    pix0_q <= pix_i;
  end

  // Stage 1: maximum and minimum channel.
  logic       vld1_q;
  pix_t       pix1_q;
  logic [7:0] mx1_q, mn1_q, mx1_d, mn1_d;
  logic       skip1_q;

  always_comb begin
    mx1_d = pix0_q.red;
    if (pix0_q.green > mx1_d) mx1_d = pix0_q.green;
    if (pix0_q.blue > mx1_d) mx1_d = pix0_q.blue;
    mn1_d = pix0_q.red;
    if (pix0_q.green < mn1_d) mn1_d = pix0_q.green;
    if (pix0_q.blue < mn1_d) mn1_d = pix0_q.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q  <= pix0_q;
    mx1_q   <= mx1_d;
    mn1_q   <= mn1_d;
    skip1_q <= (pix0_q.alpha <= alpha_thr_q);
  end

  // Stage 2: chroma and the sector-offset numerator of the hue.
  logic        vld2_q;
  s1_t         s2_q;
  logic [10:0] num2_q, num2_d;
  logic [7:0]  chroma;
  logic [8:0]  diff;
  logic [2:0]  kmul;
  logic [10:0] kc;
  logic [11:0] num12;

  assign chroma = mx1_q - mn1_q;

  always_comb begin
    if (mx1_q == pix1_q.red) begin
      diff = {1'b0, pix1_q.green} - {1'b0, pix1_q.blue};
      kmul = diff[8] ? 3'd6 : 3'd0;
    end else if (mx1_q == pix1_q.green) begin
      diff = {1'b0, pix1_q.blue} - {1'b0, pix1_q.red};
      kmul = 3'd2;
    end else begin
      diff = {1'b0, pix1_q.red} - {1'b0, pix1_q.green};
      kmul = 3'd4;
    end
    kc     = 11'(kmul) * 11'(chroma);
    num12  = {1'b0, kc} + {{3{diff[8]}}, diff};
    num2_d = num12[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q.pix    <= pix1_q;
    s2_q.mn     <= mn1_q;
    s2_q.chroma <= chroma;
    s2_q.skip   <= skip1_q || (chroma == 8'd0);
    num2_q      <= num2_d;
  end

  // Hue divider: (2P * num + C) / (2C).
  logic [N1W-1:0] n1;
  logic [D1W-1:0] d1;
  logic           vld_h;
  logic [QW1-1:0] quo_h;
  logic [$bits(s1_t)-1:0] side_h;
  s1_t            sh;

  assign n1 = N1W'(num2_q) * N1W'(2 * P) + N1W'(s2_q.chroma);
  assign d1 = {s2_q.chroma, 1'b0};

  shs_div #(
    .NW (N1W),
    .DW (D1W),
    .QW (QW1),
    .SW ($bits(s1_t))
  ) u_div_hue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld2_q),
    .num_i       (n1),
    .den_i       (d1),
    .side_i      (s2_q),
    .out_valid_o (vld_h),
    .quo_o       (quo_h),
    .side_o      (side_h)
  );

  assign sh = s1_t'(side_h);

  // Stage 3: hue wrap, window test and shift.
  logic          vld3_q;
  s1_t           s3_q;
  logic          rec3_q;
  logic [HW:0]   hsum3_q;
  logic [HW-1:0] hue;
  logic [CW-1:0] hue_c, st_c, en_c;
  logic          in_win;

  assign hue   = (quo_h >= QW1'(F)) ? '0 : HW'(quo_h);
  assign hue_c = CW'(hue);
  assign st_c  = CW'(hue_start_q);
  assign en_c  = CW'(hue_end_q);

  always_comb begin
    if (hue_end_q < hue_start_q) begin
      in_win = !((hue_c < st_c) && (hue_c > en_c));
    end else begin
      in_win = !((hue_c < st_c) || (hue_c > en_c));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld_h;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q    <= sh;
    rec3_q  <= !sh.skip && in_win;
    hsum3_q <= {1'b0, hue} + {1'b0, shift_red_q};
  end

  // Stage 4: new hue, sector and distance from the sector edge.
  logic          vld4_q;
  s2_t           s4_q;
  logic [PW-1:0] u4_q, u4_d;
  logic [HW-1:0] hn, m;
  logic [2:0]    sector;
  logic [HW-1:0] t;

  always_comb begin
    hn = (hsum3_q >= (HW + 1)'(F)) ? HW'(hsum3_q - (HW + 1)'(F)) : HW'(hsum3_q);
    if (hn < HW'(P)) begin
      sector = 3'd0;
    end else if (hn < HW'(2 * P)) begin
      sector = 3'd1;
    end else if (hn < HW'(3 * P)) begin
      sector = 3'd2;
    end else if (hn < HW'(4 * P)) begin
      sector = 3'd3;
    end else if (hn < HW'(5 * P)) begin
      sector = 3'd4;
    end else begin
      sector = 3'd5;
    end
    case (sector[2:1])
      2'd0:    m = hn;
      2'd1:    m = hn - HW'(2 * P);
      default: m = hn - HW'(4 * P);
    endcase
    t    = (m >= HW'(P)) ? (m - HW'(P)) : (HW'(P) - m);
    u4_d = PW'(HW'(P) - t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q.pix     <= s3_q.pix;
    s4_q.mn      <= s3_q.mn;
    s4_q.chroma  <= s3_q.chroma;
    s4_q.recolor <= rec3_q;
    s4_q.sector  <= sector;
    u4_q         <= u4_d;
  end

  // Stage 5: numerator of the middle channel.
  logic           vld5_q;
  s2_t            s5_q;
  logic [N2W-1:0] n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else begin
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q <= s4_q;
    n2_q <= (N2W'(s4_q.chroma) * N2W'(u4_q) << 1) + N2W'(P);
  end

  // Stage 6: middle channel (2C * u + P) / (2P) by reciprocal multiplication,
  // exact for every numerator below 2 to the power N2W.
  logic           vld6_q;
  s2_t            s6_q;
  logic [PRW-1:0] prod6_q;
  logic           vld_m;
  logic [QW2-1:0] inter;
  s2_t            sm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld6_q <= 1'b0;
    end else begin
      vld6_q <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_q    <= s5_q;
    prod6_q <= PRW'(n2_q) * PRW'(RMUL);
  end

  assign vld_m = vld6_q;
  assign inter = prod6_q[RSH +: QW2];
  assign sm    = s6_q;

  // Output stage: channel order by sector.
  logic       out_valid_q;
  res_t       res_q, res_d;
  logic [7:0] c1, c2, c3;

  assign c1 = sm.chroma + sm.mn;
  assign c2 = inter + sm.mn;
  assign c3 = sm.mn;

  always_comb begin
    res_d.red_out   = sm.pix.red;
    res_d.green_out = sm.pix.green;
    res_d.blue_out  = sm.pix.blue;
    res_d.alpha_out = sm.pix.alpha;
    res_d.recolored = 1'b0;
    if (sm.recolor) begin
      res_d.alpha_out = ALPHA_OPAQUE;
      res_d.recolored = 1'b1;
      case (sm.sector)
        3'd0: begin
          res_d.red_out = c1; res_d.green_out = c2; res_d.blue_out = c3;
        end
        3'd1: begin
          res_d.red_out = c2; res_d.green_out = c1; res_d.blue_out = c3;
        end
        3'd2: begin
          res_d.red_out = c3; res_d.green_out = c1; res_d.blue_out = c2;
        end
        3'd3: begin
          res_d.red_out = c3; res_d.green_out = c2; res_d.blue_out = c1;
        end
        3'd4: begin
          res_d.red_out = c2; res_d.green_out = c3; res_d.blue_out = c1;
        end
        default: begin
          res_d.red_out = c1; res_d.green_out = c3; res_d.blue_out = c2;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= vld_m;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Every accepted word leaves after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT out_valid_o)
    else $error("result missing after pipeline latency");

  // A recolored word is opaque.
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.recolored) |-> (res_o.alpha_out == ALPHA_OPAQUE))
    else $error("recolored word is not opaque");

  // A word that passes through keeps its red channel and its alpha.
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !res_o.recolored) |->
      (res_o.red_out == $past(pix_i.red, LAT)) &&
      (res_o.alpha_out == $past(pix_i.alpha, LAT)))
    else $error("pass-through word changed");

  // A gray word or one at or below the alpha threshold is never recolored.
  a_gray_never: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.recolored) |->
      (($past(pix_i.alpha, LAT) > alpha_thr_q) &&
       !(($past(pix_i.red, LAT) == $past(pix_i.green, LAT)) &&
         ($past(pix_i.green, LAT) == $past(pix_i.blue, LAT)))))
    else $error("gray or transparent word was recolored");

endmodule

`default_nettype wire

### tb/sv/hue_shift_checker.sv
`timescale 1ns / 1ps

module hue_shift_checker
  import shs_pkg::*;
#(
  parameter int unsigned HUE_STEPS_PER_DEGREE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  pix_t        pix_i,
  input  logic        out_valid_o,
  input  res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);

  localparam int SECTOR      = 60 * HUE_STEPS_PER_DEGREE;
  localparam int FULL_CIRCLE = 360 * HUE_STEPS_PER_DEGREE;

  logic [7:0]  alpha_thr;
  logic [12:0] win_start;
  logic [12:0] win_end;
  logic [12:0] rotation;

  res_t expected_q[$];
  res_t want;

  function automatic res_t recolor_pixel(pix_t p);
    res_t r;
    int   mx;
    int   mn;
    int   c;
    int   d;
    int   k;
    int   hue;
    int   hn;
    int   m;
    int   t;
    int   mid;
    int   top;
    int   bot;
    int   lo;
    int   hi;
    bit   hit;
    r.red_out   = p.red;
    r.green_out = p.green;
    r.blue_out  = p.blue;
    r.alpha_out = p.alpha;
    r.recolored = 1'b0;
    if (p.alpha <= alpha_thr) begin
      return r;
    end
    mx = p.red;
    if (p.green > mx) mx = p.green;
    if (p.blue > mx) mx = p.blue;
    mn = p.red;
    if (p.green < mn) mn = p.green;
    if (p.blue < mn) mn = p.blue;
    c = mx - mn;
    if (c == 0) begin
      return r;
    end
    if (mx == p.red) begin
      d = int'(p.green) - int'(p.blue);
      k = (d < 0) ? 6 : 0;
    end else if (mx == p.green) begin
      d = int'(p.blue) - int'(p.red);
      k = 2;
    end else begin
      d = int'(p.red) - int'(p.green);
      k = 4;
    end
    hue = (2 * SECTOR * (d + k * c) + c) / (2 * c);
    if (hue >= FULL_CIRCLE) hue -= FULL_CIRCLE;
    lo = int'(win_start);
    hi = int'(win_end);
    if (hi < lo) hit = !((hue < lo) && (hue > hi));
    else hit = !((hue < lo) || (hue > hi));
    if (!hit) begin
      return r;
    end
    hn  = (hue + (int'(rotation) % FULL_CIRCLE)) % FULL_CIRCLE;
    m   = hn % (2 * SECTOR);
    t   = (m >= SECTOR) ? (m - SECTOR) : (SECTOR - m);
    mid = (2 * c * (SECTOR - t) + SECTOR) / (2 * SECTOR) + mn;
    top = c + mn;
    bot = mn;
    case (hn / SECTOR)
      0: begin
        r.red_out = 8'(top); r.green_out = 8'(mid); r.blue_out = 8'(bot);
      end
      1: begin
        r.red_out = 8'(mid); r.green_out = 8'(top); r.blue_out = 8'(bot);
      end
      2: begin
        r.red_out = 8'(bot); r.green_out = 8'(top); r.blue_out = 8'(mid);
      end
      3: begin
        r.red_out = 8'(bot); r.green_out = 8'(mid); r.blue_out = 8'(top);
      end
      4: begin
        r.red_out = 8'(mid); r.green_out = 8'(bot); r.blue_out = 8'(top);
      end
      default: begin
        r.red_out = 8'(top); r.green_out = 8'(bot); r.blue_out = 8'(mid);
      end
    endcase
    r.alpha_out = ALPHA_OPAQUE;
    r.recolored = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_ALPHA_THR: return {24'd0, alpha_thr};
      REG_HUE_START: return {19'd0, win_start};
      REG_HUE_END:   return {19'd0, win_end};
      default:       return {19'd0, rotation};
    endcase
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_thr = ALPHA_THR_RST;
      win_start = HUE_START_RST;
      win_end   = HUE_END_RST;
      rotation  = HUE_SHIFT_RST;
      expected_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(recolor_pixel(pix_i));
      end
      if (out_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word expected none actual %0h", $time, res_o);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("red_out", want.red_out, res_o.red_out);
          check_field("green_out", want.green_out, res_o.green_out);
          check_field("blue_out", want.blue_out, res_o.blue_out);
          check_field("alpha_out", want.alpha_out, res_o.alpha_out);
          check_field("recolored", want.recolored, res_o.recolored);
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_ALPHA_THR: alpha_thr = pwdata[7:0];
            REG_HUE_START: win_start = pwdata[12:0];
            REG_HUE_END:   win_end   = pwdata[12:0];
            default:       rotation  = pwdata[12:0];
          endcase
        end else begin
          check_field("prdata", reg_value(paddr[3:2]), prdata);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### tb/sv/selective_hue_shift_test.sv
`timescale 1ns / 1ps

module selective_hue_shift_test;
  import shs_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_CYCLES    = 200000;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 75;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  pix_t        pix_i   = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        out_valid_o;
  res_t        res_o;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycles = 0;

  // Threshold, window start, window end and shift per phase; -1 picks a random value.
  int phase_cfg [PHASES][4] = '{
    '{0, 0, 5759, 0},
    '{255, 0, 5759, 1000},
    '{128, 4800, 960, 5759},
    '{1, 960, 2880, 8191},
    '{0, 6000, 100, 2880},
    '{254, 100, 8191, 1920},
    '{0, 8191, 480, 4800},
    '{-1, -1, -1, -1},
    '{-1, -1, -1, -1},
    '{-1, -1, -1, -1}
  };

  logic [31:0] directed [22] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'hFF0000FF, 32'h00FF00FF,
    32'h0000FFFF, 32'hFFFF00FF, 32'h00FFFFFF, 32'hFF00FFFF, 32'hFF0001FF,
    32'h0100FFFF, 32'hFF000000, 32'hFF000001, 32'h12345680, 32'h010000FF,
    32'hFEFFFDFF, 32'h7F8081FF, 32'hAA55AAFF, 32'h55AA55FF, 32'h0FF03C7E,
    32'h800040FF, 32'h01020304
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  selective_hue_shift u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hue_shift_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic apb_xfer(input logic write, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (idx == REG_ALPHA_THR) ? 32'h000000FF : 32'h00001FFF;
    data = value & mask;
    if ($urandom_range(0, 2) == 0) data |= $urandom() & ~mask;
    apb_xfer(1'b1, idx, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int thr, input int hs, input int he, input int sh);
    drain();
    write_reg(REG_ALPHA_THR, thr);
    write_reg(REG_HUE_START, hs);
    write_reg(REG_HUE_END, he);
    write_reg(REG_HUE_SHIFT, sh);
    apb_xfer(1'b0, REG_ALPHA_THR, '0);
    apb_xfer(1'b0, REG_HUE_START, '0);
    apb_xfer(1'b0, REG_HUE_END, '0);
    apb_xfer(1'b0, REG_HUE_SHIFT, '0);
  endtask

  task automatic send_pixel(input pix_t p);
    start <= 1'b1;
    pix_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) begin
      pix_i <= $urandom();
      @(posedge clk_i);
    end
  endtask

  function automatic pix_t rand_pixel(int thr);
    pix_t p;
    int   hi;
    int   lo;
    p = $urandom();
    if (thr < 255 && $urandom_range(0, 7) != 0) p.alpha = 8'($urandom_range(255, thr + 1));
    case ($urandom_range(0, 9))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: begin
        hi = $urandom_range(255, 1);
        lo = $urandom_range(hi - 1, 0);
        case ($urandom_range(0, 2))
          0: begin p.red = 8'(hi); p.green = 8'(hi); p.blue = 8'(lo); end
          1: begin p.red = 8'(lo); p.green = 8'(hi); p.blue = 8'(hi); end
          default: begin p.red = 8'(hi); p.green = 8'(lo); p.blue = 8'(hi); end
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int thr;
    int hs;
    int he;
    int sh;
    int quiet;
    quiet = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++) apb_xfer(1'b0, 2'(i), '0);

    configure(0, 0, 5759, 960);
    foreach (directed[i]) begin
      send_pixel(pix_t'(directed[i]));
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 8));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      thr = (phase_cfg[ph][0] < 0) ? $urandom_range(0, 255) : phase_cfg[ph][0];
      hs  = (phase_cfg[ph][1] < 0) ? $urandom_range(0, 5759) : phase_cfg[ph][1];
      he  = (phase_cfg[ph][2] < 0) ? $urandom_range(0, 5759) : phase_cfg[ph][2];
      sh  = (phase_cfg[ph][3] < 0) ? $urandom_range(0, 8191) : phase_cfg[ph][3];
      configure(thr, hs, he, sh);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_pixel(rand_pixel(thr));
        if (ph != PHASES - 1) begin
          if ((ph == 2 && n == 37) || $urandom_range(0, 150) == 0) begin
            drain();
          end else if (quiet > 0) begin
            quiet--;
          end else if ($urandom_range(0, 3) == 0) begin
            idle_gap($urandom_range(1, 8));
          end else if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(10, 30);
          end
        end
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
